@@ rtl/pat_pkg.sv @@
package pat_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int ADDR_BYTES_DEF = 5;

    localparam int ADDR_W  = 40;
    localparam int SEL_W   = 5;
    localparam int PNUM_W  = 8;
    localparam int REQ_W   = 2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // unused slot: every address byte is ASCII '0'
    localparam logic [ADDR_W-1:0] FREE_ADDR = 40'h30_3030_3030;
    localparam logic [7:0]        FREE_MARK = 8'h30;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER = 2'd0,
        REQ_SEARCH   = 2'd1,
        REQ_ASSIGN   = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

endpackage

@@ rtl/pat_ram.sv @@
module pat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/peer_address_table.sv @@
// Channel  Dir  Handshake             Payload
// s_axis   in   s_tvalid / s_tready   s_tdata: peer_addr, slot_sel, peri_num_in
//                                     s_tuser: req_type
// m_axis   out  m_tvalid / m_tready   m_tdata: slot_index, hit, newly_added,
//                                              peri_num_out, status
//
// Register and search walk slots 1..SLOTS-1 through one read port of each store,
// one slot per cycle, stopping at the first match, then load the result in the
// deliver state. Assign and unknown requests go straight to the deliver state.
// The next item is taken only after the result of the last has been loaded.
// Reset marks every entry unwritten; unwritten entries read as "00000" and 0.
// s_tready is low while a request is in work or its result cannot be loaded;
// a result held on m_tdata does not block the next accept.
module peer_address_table #(
    parameter int SLOTS      = pat_pkg::SLOTS_DEF,
    parameter int ADDR_BYTES = pat_pkg::ADDR_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [39:0] peer_addr, [44:40] slot_sel, [52:45] peri_num_in, [55:53] zero
    input  logic [pat_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [pat_pkg::REQ_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [4:0] slot_index, [5] hit, [6] newly_added, [14:7] peri_num_out, [15] status
    output logic [pat_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int DEPTH = SLOTS + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int EXT_W = IDX_W + pat_pkg::SEL_W;

    localparam logic [IDX_W-1:0] SLOTS_IDX = IDX_W'(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [EXT_W-1:0] SLOTS_EXT = EXT_W'(SLOTS);

    localparam logic [pat_pkg::ADDR_W-1:0] CMP_MASK =
        ~((40'd1 << (8 * (5 - ADDR_BYTES))) - 40'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DELIVER
    } state_t;

    function automatic logic [pat_pkg::SEL_W-1:0] to_slot5(input logic [IDX_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = {{pat_pkg::SEL_W{1'b0}}, v};
        return ext[pat_pkg::SEL_W-1:0];
    endfunction

    state_t                        state_reg;
    pat_pkg::req_t                 req_reg;
    logic [pat_pkg::ADDR_W-1:0]    addr_reg;
    logic [IDX_W-1:0]              scan_idx_reg;
    logic [IDX_W-1:0]              cmp_idx_reg;
    logic                          cmp_vld_reg;
    logic                          avld_q_reg;
    logic                          nvld_q_reg;
    logic [IDX_W-1:0]              free_slot_reg;
    logic                          free_found_reg;
    logic [DEPTH-1:0]              addr_vld_reg;
    logic [DEPTH-1:0]              num_vld_reg;

    logic [pat_pkg::SEL_W-1:0]     res_slot_reg;
    logic                          res_hit_reg;
    logic                          res_added_reg;
    logic [pat_pkg::PNUM_W-1:0]    res_pnum_reg;
    logic                          res_status_reg;

    logic                          m_valid_reg;
    logic [pat_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic [pat_pkg::ADDR_W-1:0]    in_addr;
    logic [pat_pkg::SEL_W-1:0]     in_sel;
    logic [pat_pkg::PNUM_W-1:0]    in_pnum;
    logic [EXT_W-1:0]              sel_ext;
    logic                          sel_bad;
    logic                          accept;
    logic                          in_assign;

    logic [pat_pkg::ADDR_W-1:0]    addr_rdata;
    logic [pat_pkg::PNUM_W-1:0]    num_rdata;
    logic [pat_pkg::ADDR_W-1:0]    cur_addr;
    logic [pat_pkg::PNUM_W-1:0]    cur_num;
    logic                          cur_match;
    logic                          cur_free;
    logic                          cmp_last;
    logic                          issue;
    logic                          scan_done;

    logic                          addr_we;
    logic [IDX_W-1:0]              addr_waddr;
    logic [pat_pkg::ADDR_W-1:0]    addr_wdata;
    logic                          num_we;
    logic                          out_free;

    assign in_addr   = s_tdata[39:0];
    assign in_sel    = s_tdata[44:40];
    assign in_pnum   = s_tdata[52:45];
    assign sel_ext   = {{IDX_W{1'b0}}, in_sel};
    assign sel_bad   = sel_ext > SLOTS_EXT;
    assign in_assign = (pat_pkg::req_t'(s_tuser) == pat_pkg::REQ_ASSIGN);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign cur_addr  = avld_q_reg ? addr_rdata : pat_pkg::FREE_ADDR;
    assign cur_num   = nvld_q_reg ? num_rdata : '0;
    assign cur_match = ((cur_addr ^ addr_reg) & CMP_MASK) == '0;
    assign cur_free  = cur_addr[39:32] == pat_pkg::FREE_MARK;
    assign cmp_last  = cmp_idx_reg == LAST_IDX;
    assign issue     = scan_idx_reg <= LAST_IDX;
    assign scan_done = cmp_vld_reg && (cur_match || cmp_last);

    // on the last slot with no match, register takes the lowest free slot seen
    assign addr_we    = (state_reg == ST_SCAN) && cmp_vld_reg && !cur_match && cmp_last
                        && (req_reg == pat_pkg::REQ_REGISTER)
                        && (free_found_reg || cur_free);
    assign addr_waddr = free_found_reg ? free_slot_reg : cmp_idx_reg;
    assign addr_wdata = (pat_pkg::FREE_ADDR & ~CMP_MASK) | (addr_reg & CMP_MASK);

    assign num_we = accept && in_assign && !sel_bad;

    pat_ram #(
        .WIDTH (pat_pkg::ADDR_W),
        .DEPTH (DEPTH)
    ) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (addr_waddr),
        .wdata (addr_wdata),
        .raddr (scan_idx_reg),
        .rdata (addr_rdata)
    );

    pat_ram #(
        .WIDTH (pat_pkg::PNUM_W),
        .DEPTH (DEPTH)
    ) u_num_ram (
        .clk   (clk),
        .we    (num_we),
        .waddr (sel_ext[IDX_W-1:0]),
        .wdata (in_pnum),
        .raddr (scan_idx_reg),
        .rdata (num_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= pat_pkg::REQ_REGISTER;
            addr_reg       <= '0;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            avld_q_reg     <= 1'b0;
            nvld_q_reg     <= 1'b0;
            free_slot_reg  <= '0;
            free_found_reg <= 1'b0;
            addr_vld_reg   <= '0;
            num_vld_reg    <= '0;
            res_slot_reg   <= '0;
            res_hit_reg    <= 1'b0;
            res_added_reg  <= 1'b0;
            res_pnum_reg   <= '0;
            res_status_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            if (m_valid_reg && m_tready && (state_reg != ST_DELIVER))
            begin
                m_valid_reg <= 1'b0;
            end

            if (addr_we)
            begin
                addr_vld_reg[addr_waddr] <= 1'b1;
            end
            if (num_we)
            begin
                num_vld_reg[sel_ext[IDX_W-1:0]] <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg        <= pat_pkg::req_t'(s_tuser);
                        addr_reg       <= in_addr;
                        scan_idx_reg   <= IDX_W'(1);
                        cmp_vld_reg    <= 1'b0;
                        free_found_reg <= 1'b0;
                        res_slot_reg   <= in_assign ? in_sel : '0;
                        res_hit_reg    <= 1'b0;
                        res_added_reg  <= 1'b0;
                        res_pnum_reg   <= '0;
                        res_status_reg <= in_assign && sel_bad;
                        case (pat_pkg::req_t'(s_tuser))
                            pat_pkg::REQ_REGISTER, pat_pkg::REQ_SEARCH:
                            begin
                                state_reg <= ST_SCAN;
                            end
                            pat_pkg::REQ_ASSIGN:
                            begin
                                state_reg <= ST_DELIVER;
                            end
                            default:
                            begin
                                state_reg <= ST_DELIVER;
                            end
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    cmp_idx_reg <= scan_idx_reg;
                    cmp_vld_reg <= issue && !scan_done;
                    avld_q_reg  <= addr_vld_reg[scan_idx_reg];
                    nvld_q_reg  <= num_vld_reg[scan_idx_reg];
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                    end

                    if (cmp_vld_reg)
                    begin
                        if (cur_match)
                        begin
                            res_slot_reg <= to_slot5(cmp_idx_reg);
                            res_hit_reg  <= 1'b1;
                            res_pnum_reg <= (req_reg == pat_pkg::REQ_SEARCH) ? cur_num : '0;
                            state_reg    <= ST_DELIVER;
                        end
                        else
                        begin
                            if (!free_found_reg && cur_free)
                            begin
                                free_found_reg <= 1'b1;
                                free_slot_reg  <= cmp_idx_reg;
                            end
                            if (cmp_last)
                            begin
                                if (addr_we)
                                begin
                                    res_slot_reg  <= to_slot5(addr_waddr);
                                    res_hit_reg   <= 1'b1;
                                    res_added_reg <= 1'b1;
                                end
                                else
                                begin
                                    res_slot_reg <= to_slot5(SLOTS_IDX);
                                end
                                state_reg <= ST_DELIVER;
                            end
                        end
                    end
                end

                ST_DELIVER:
                begin
                    // a held result that is not taken keeps m_tvalid high
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {res_status_reg, res_pnum_reg, res_added_reg,
                                        res_hit_reg, res_slot_reg};
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ sim/tb_peer_address_table.sv @@
module tb_peer_address_table;

    localparam int SLOTS      = pat_pkg::SLOTS_DEF;
    localparam int ADDR_BYTES = pat_pkg::ADDR_BYTES_DEF;
    localparam int N_RANDOM   = 1500;
    localparam int POOL_N     = 12;

    // only the top ADDR_BYTES bytes take part in compare and write
    localparam logic [63:0] ADDR_ONES = (64'd1 << (8 * ADDR_BYTES)) - 64'd1;
    localparam logic [pat_pkg::ADDR_W-1:0] CMP_MASK =
        pat_pkg::ADDR_W'(ADDR_ONES << (8 * (5 - ADDR_BYTES)));

    typedef struct {
        pat_pkg::req_t              kind;
        logic [pat_pkg::ADDR_W-1:0] addr;
        logic [pat_pkg::SEL_W-1:0]  sel;
        logic [pat_pkg::PNUM_W-1:0] pnum;
        bit                         drain;   // wait until all replies are in before offering
    } request_t;

    typedef struct {
        logic [pat_pkg::SEL_W-1:0]  slot;
        logic                       hit;
        logic                       added;
        logic [pat_pkg::PNUM_W-1:0] pnum;
        logic                       status;
    } reply_t;

    logic                            clk;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pat_pkg::IN_DATA_W-1:0]   s_tdata  = '0;
    logic [pat_pkg::REQ_W-1:0]       s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pat_pkg::OUT_DATA_W-1:0]  m_tdata;

    logic [pat_pkg::ADDR_W-1:0] addr_tbl [0:SLOTS];
    logic [pat_pkg::PNUM_W-1:0] num_tbl  [0:SLOTS];

    request_t requests_todo [$];
    reply_t   replies_due   [$];
    request_t cur_req;
    logic [pat_pkg::ADDR_W-1:0] addr_pool [POOL_N];

    int n_sent     = 0;
    int n_replies  = 0;
    int mismatches = 0;
    int hold_left  = 0;
    bit hold_done  = 0;

    peer_address_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("** peer_address_table: FAILED **");
        $finish;
    end

    function automatic request_t make_req(pat_pkg::req_t kind,
                                          logic [pat_pkg::ADDR_W-1:0] addr,
                                          logic [pat_pkg::SEL_W-1:0] sel,
                                          logic [pat_pkg::PNUM_W-1:0] pnum);
        request_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.sel   = sel;
        r.pnum  = pnum;
        r.drain = 1'b0;
        return r;
    endfunction

    // table update and reply for one accepted request
    task automatic serve_request(input request_t r);
        reply_t rp;
        int     free_slot;
        bit     found;
        rp        = '{default: '0};
        free_slot = 0;
        found     = 1'b0;
        case (r.kind)
            pat_pkg::REQ_REGISTER, pat_pkg::REQ_SEARCH:
            begin
                rp.slot = pat_pkg::SEL_W'(SLOTS);
                for (int i = 1; i < SLOTS; i++)
                begin
                    if (!found)
                    begin
                        if (((addr_tbl[i] ^ r.addr) & CMP_MASK) == '0)
                        begin
                            found   = 1'b1;
                            rp.slot = pat_pkg::SEL_W'(i);
                            rp.hit  = 1'b1;
                            if (r.kind == pat_pkg::REQ_SEARCH)
                                rp.pnum = num_tbl[i];
                        end
                        else if (free_slot == 0 && addr_tbl[i][39:32] == pat_pkg::FREE_MARK)
                            free_slot = i;
                    end
                end
                if (r.kind == pat_pkg::REQ_REGISTER && !found && free_slot != 0)
                begin
                    addr_tbl[free_slot] = (addr_tbl[free_slot] & ~CMP_MASK) | (r.addr & CMP_MASK);
                    rp.slot  = pat_pkg::SEL_W'(free_slot);
                    rp.hit   = 1'b1;
                    rp.added = 1'b1;
                end
            end
            pat_pkg::REQ_ASSIGN:
            begin
                rp.slot = r.sel;
                if (r.sel > SLOTS)
                    rp.status = 1'b1;
                else
                    num_tbl[r.sel] = r.pnum;
            end
            default:
                rp = '{default: '0};
        endcase
        replies_due.push_back(rp);
    endtask

    task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic go;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                serve_request(cur_req);
                n_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                go = requests_todo.size() > 0;
                if (go && requests_todo[0].drain && replies_due.size() != 0)
                    go = 1'b0;
                if (go && !(n_sent >= 700 && n_sent < 950) && $urandom_range(0, 99) < 16)
                    go = 1'b0;
                if (go)
                begin
                    cur_req = requests_todo.pop_front();
                    s_tdata <= {3'b000, cur_req.pnum, cur_req.sel, cur_req.addr};
                    s_tuser <= cur_req.kind;
                end
                s_tvalid <= go;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.slot   = m_tdata[4:0];
                got.hit    = m_tdata[5];
                got.added  = m_tdata[6];
                got.pnum   = m_tdata[14:7];
                got.status = m_tdata[15];
                n_replies++;
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual %04h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.slot !== want.slot)
                        report("slot_index", 8'(want.slot), 8'(got.slot));
                    if (got.hit !== want.hit)
                        report("hit", 8'(want.hit), 8'(got.hit));
                    if (got.added !== want.added)
                        report("newly_added", 8'(want.added), 8'(got.added));
                    if (got.pnum !== want.pnum)
                        report("peri_num_out", want.pnum, got.pnum);
                    if (got.status !== want.status)
                        report("status", 8'(want.status), 8'(got.status));
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && n_replies >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 250;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (n_replies >= 700 && n_replies < 950) || $urandom_range(0, 99) >= 16;
        end
    end

    initial
    begin
        request_t r;
        int       pick;
        for (int i = 0; i <= SLOTS; i++)
        begin
            addr_tbl[i] = pat_pkg::FREE_ADDR;
            num_tbl[i]  = '0;
        end

        // free-looking address matches an untouched slot
        requests_todo.push_back(make_req(pat_pkg::REQ_SEARCH, pat_pkg::FREE_ADDR, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_REGISTER, pat_pkg::FREE_ADDR, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_REGISTER, '1, '1, '1));
        requests_todo.push_back(make_req(pat_pkg::REQ_REGISTER, '0, '0, '0));
        // first byte '0': slot stays free and the next new address overwrites it
        requests_todo.push_back(make_req(pat_pkg::REQ_REGISTER, 40'h30_0000_0001, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_REGISTER, 40'h30_1122_3344, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_SEARCH, 40'h30_0000_0001, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_ASSIGN, '0, 5'd0, 8'hFF));
        requests_todo.push_back(make_req(pat_pkg::REQ_ASSIGN, '0, 5'(SLOTS), 8'h5A));
        requests_todo.push_back(make_req(pat_pkg::REQ_ASSIGN, '0, 5'd1, 8'hA5));
        requests_todo.push_back(make_req(pat_pkg::REQ_ASSIGN, '1, 5'(SLOTS + 1), 8'h33));
        requests_todo.push_back(make_req(pat_pkg::REQ_ASSIGN, '0, '1, '1));
        requests_todo.push_back(make_req(pat_pkg::REQ_SEARCH, '1, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_SEARCH, '0, '1, '1));
        requests_todo.push_back(make_req(pat_pkg::REQ_NONE, '1, '1, '1));
        requests_todo.push_back(make_req(pat_pkg::REQ_NONE, '0, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_SEARCH, 40'h12_3456_789A, '0, '0));
        requests_todo.push_back(make_req(pat_pkg::REQ_ASSIGN, '0, 5'd2, 8'h00));
        requests_todo.push_back(make_req(pat_pkg::REQ_SEARCH, 40'h30_1122_3344, '0, '0));

        for (int k = 0; k < POOL_N; k++)
        begin
            addr_pool[k] = {8'($urandom), 32'($urandom)};
            if (k < 3)
                addr_pool[k][39:32] = pat_pkg::FREE_MARK;
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                r.kind = pat_pkg::REQ_REGISTER;
            else if (pick < 70)
                r.kind = pat_pkg::REQ_SEARCH;
            else if (pick < 92)
                r.kind = pat_pkg::REQ_ASSIGN;
            else
                r.kind = pat_pkg::REQ_NONE;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                r.addr = addr_pool[$urandom_range(0, POOL_N - 1)];
            else if (pick < 90)
                r.addr = pat_pkg::FREE_ADDR;
            else
                r.addr = {8'($urandom), 32'($urandom)};
            if ($urandom_range(0, 99) < 80)
                r.sel = pat_pkg::SEL_W'($urandom_range(0, SLOTS));
            else
                r.sel = pat_pkg::SEL_W'($urandom_range(SLOTS + 1, 31));
            r.pnum  = pat_pkg::PNUM_W'($urandom_range(0, 255));
            r.drain = (n == 0 || n == 1000);
            requests_todo.push_back(r);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_todo.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        if (mismatches == 0 && replies_due.size() == 0)
            $display("** peer_address_table: PASSED **");
        else
            $display("** peer_address_table: FAILED **");
        $finish;
    end

endmodule

@@ peer_address_table.f @@
rtl/pat_pkg.sv
rtl/pat_ram.sv
rtl/peer_address_table.sv
sim/tb_peer_address_table.sv
